>>> rtl/core/apf_pkg.sv
// Shared constants, types and command codes of the articulation point finder.
package apf_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int MAX_EDGES    = 256;
    localparam int LINK_SLOTS   = 2 * MAX_EDGES;
    localparam int V_W          = $clog2(MAX_VERTICES);
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
    localparam int DISC_W       = $clog2(MAX_VERTICES + 2);
    localparam int SLOT_W       = $clog2(LINK_SLOTS);
    localparam int EDGE_W       = $clog2(MAX_EDGES + 1);
    localparam int CFG_W        = 7;
    localparam int VTX_OUT_W    = 6;

    // One level of the search stack
    typedef struct packed {
        logic [V_W-1:0]    node;
        logic [V_W-1:0]    parent;
        logic              has_parent;
        logic              cursor_valid;
        logic [SLOT_W-1:0] cursor;
        logic [1:0]        kids;
        logic [DISC_W-1:0] disc;
        logic [DISC_W-1:0] low;
    } frame_t;

    // One entry of the adjacency link store
    typedef struct packed {
        logic              next_valid;
        logic [SLOT_W-1:0] next;
        logic [V_W-1:0]    neighbor;
    } link_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_ADD,
        OP_ADD_FIRST,
        OP_ADD_SECOND,
        OP_START,
        OP_SCAN,
        OP_LOAD_CURSOR,
        OP_EDGE_READ,
        OP_EDGE_EVAL,
        OP_BACK_CMP,
        OP_POP,
        OP_POP_MERGE,
        OP_EMIT,
        OP_CLEAR
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADD_FIRST,
        ST_ADD_SECOND,
        ST_SCAN,
        ST_LOAD_CURSOR,
        ST_EDGE_READ,
        ST_EDGE_EVAL,
        ST_BACK_CMP,
        ST_POP_MERGE,
        ST_EMIT,
        ST_CLEAR
    } state_t;

    typedef struct packed {
        op_t op;
    } ctl_cmd_t;

    typedef struct packed {
        logic add_ok;
        logic scan_end;
        logic scan_visited;
        logic cursor_valid;
        logic has_parent;
        logic push;
        logic back;
        logic emit_done;
    } dp_status_t;

endpackage

>>> rtl/core/apf_ctrl.sv
// Sequencer for edge loading, depth-first search, result emission and clearing.
module apf_ctrl
    import apf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       req_type,
    input  dp_status_t status,
    output ctl_cmd_t   cmd
);

    state_t state_reg;
    state_t state_next;

    // Hold the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Decide next state and the datapath command
    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (req_type)
                    begin
                        cmd.op     = OP_START;
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        cmd.op     = OP_ADD;
                        state_next = status.add_ok ? ST_ADD_FIRST : ST_IDLE;
                    end
                end
            end
            ST_ADD_FIRST:
            begin
                cmd.op     = OP_ADD_FIRST;
                state_next = ST_ADD_SECOND;
            end
            ST_ADD_SECOND:
            begin
                cmd.op     = OP_ADD_SECOND;
                state_next = ST_IDLE;
            end
            ST_SCAN:
            begin
                cmd.op = OP_SCAN;
                if (status.scan_end)
                begin
                    state_next = ST_EMIT;
                end
                else if (!status.scan_visited)
                begin
                    state_next = ST_LOAD_CURSOR;
                end
            end
            ST_LOAD_CURSOR:
            begin
                cmd.op     = OP_LOAD_CURSOR;
                state_next = ST_EDGE_READ;
            end
            ST_EDGE_READ:
            begin
                if (status.cursor_valid)
                begin
                    cmd.op     = OP_EDGE_READ;
                    state_next = ST_EDGE_EVAL;
                end
                else
                begin
                    cmd.op     = OP_POP;
                    state_next = status.has_parent ? ST_POP_MERGE : ST_SCAN;
                end
            end
            ST_EDGE_EVAL:
            begin
                cmd.op = OP_EDGE_EVAL;
                if (status.push)
                begin
                    state_next = ST_LOAD_CURSOR;
                end
                else if (status.back)
                begin
                    state_next = ST_BACK_CMP;
                end
                else
                begin
                    state_next = ST_EDGE_READ;
                end
            end
            ST_BACK_CMP:
            begin
                cmd.op     = OP_BACK_CMP;
                state_next = ST_EDGE_READ;
            end
            ST_POP_MERGE:
            begin
                cmd.op     = OP_POP_MERGE;
                state_next = ST_EDGE_READ;
            end
            ST_EMIT:
            begin
                cmd.op = OP_EMIT;
                if (status.emit_done)
                begin
                    state_next = ST_CLEAR;
                end
            end
            ST_CLEAR:
            begin
                cmd.op     = OP_CLEAR;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/core/apf_datapath.sv
// Graph store, search stack, visit bookkeeping and result register.
module apf_datapath
    import apf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  ctl_cmd_t             cmd,
    output dp_status_t           status,
    input  logic                 cfg_valid,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic [V_W-1:0]       in_u,
    input  logic [V_W-1:0]       in_v,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [VTX_OUT_W-1:0] vertex,
    output logic                 none_found,
    output logic                 edge_error,
    output logic                 last
);

    // Memories
    logic [SLOT_W-1:0] head_mem [MAX_VERTICES];
    link_t             link_mem [LINK_SLOTS];
    logic [DISC_W-1:0] disc_mem [MAX_VERTICES];
    frame_t            stack_mem [MAX_VERTICES];

    // Registers
    logic [CFG_W-1:0]        vcount_reg;
    logic [EDGE_W-1:0]       stored_reg;
    logic                    dropped_reg;
    logic                    err_reg;
    logic [V_W-1:0]          u_reg;
    logic [V_W-1:0]          v_reg;
    logic [CNT_W-1:0]        idx_reg;
    logic [CNT_W-1:0]        top_reg;
    logic [DISC_W-1:0]       vcnt_reg;
    frame_t                  cur_reg;
    logic [DISC_W-1:0]       popx_low_reg;
    logic [MAX_VERTICES-1:0] visited_reg;
    logic [MAX_VERTICES-1:0] cut_reg;
    logic [MAX_VERTICES-1:0] head_vld_reg;
    logic                    ha_vld_reg;
    logic                    hb_vld_reg;
    logic [SLOT_W-1:0]       ha_q;
    logic [SLOT_W-1:0]       hb_q;
    link_t                   link_q;
    logic [DISC_W-1:0]       disc_q;
    frame_t                  stk_q;
    logic                    out_valid_reg;
    logic [V_W-1:0]          vertex_reg;
    logic                    none_reg;
    logic                    err_out_reg;
    logic                    last_reg;

    // Combinational helpers
    logic [CNT_W-1:0]        n_eff;
    logic [V_W-1:0]          idx_v;
    logic [V_W-1:0]          w;
    logic                    skip;
    logic                    root_start;
    logic                    out_free;
    logic                    any_cut;
    logic                    cut_here;
    logic [MAX_VERTICES-1:0] idx_onehot;
    logic                    rest_empty;
    logic                    emit_load;
    logic [SLOT_W-1:0]       slot0;
    logic [SLOT_W-1:0]       slot1;
    logic                    ha_rd;
    logic [V_W-1:0]          ha_raddr;
    logic                    head_wr;
    logic [V_W-1:0]          head_waddr;
    logic [SLOT_W-1:0]       head_wdata;
    logic                    link_wr;
    logic [SLOT_W-1:0]       link_waddr;
    link_t                   link_wdata;
    logic                    disc_wr;
    frame_t                  cur_adv;
    frame_t                  merged;
    logic [V_W-1:0]          stk_waddr;
    logic [V_W-1:0]          stk_raddr;

    // Derive the effective vertex count and the decision signals
    always_comb
    begin
        n_eff      = (vcount_reg > CFG_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES)
                                                         : CNT_W'(vcount_reg);
        idx_v      = idx_reg[V_W-1:0];
        w          = link_q.neighbor;
        skip       = cur_reg.has_parent && (w == cur_reg.parent);
        root_start = (idx_reg < n_eff) && !visited_reg[idx_v];
        out_free   = !out_valid_reg || out_ready;
        any_cut    = |cut_reg;
        cut_here   = cut_reg[idx_v];
        idx_onehot = {{(MAX_VERTICES-1){1'b0}}, 1'b1} << idx_v;
        rest_empty = (cut_reg & ~idx_onehot) == '0;
        emit_load  = (cmd.op == OP_EMIT) && out_free && (!any_cut || cut_here);
        slot0      = SLOT_W'({stored_reg, 1'b0});
        slot1      = SLOT_W'({stored_reg, 1'b1});
        stk_waddr  = V_W'(top_reg - CNT_W'(1));
        stk_raddr  = V_W'(top_reg - CNT_W'(2));

        status.add_ok       = (CNT_W'(in_u) < n_eff) && (CNT_W'(in_v) < n_eff)
                              && (stored_reg < EDGE_W'(MAX_EDGES));
        status.scan_end     = idx_reg >= n_eff;
        status.scan_visited = visited_reg[idx_v];
        status.cursor_valid = cur_reg.cursor_valid;
        status.has_parent   = cur_reg.has_parent;
        status.push         = !skip && !visited_reg[w];
        status.back         = !skip && visited_reg[w];
        status.emit_done    = out_free && (!any_cut || (cut_here && rest_empty));

        cur_adv              = cur_reg;
        cur_adv.cursor_valid = link_q.next_valid;
        cur_adv.cursor       = link_q.next;

        merged      = stk_q;
        merged.low  = (popx_low_reg < stk_q.low) ? popx_low_reg : stk_q.low;
        merged.kids = (stk_q.kids == 2'b11) ? 2'b11 : stk_q.kids + 2'b01;
    end

    // Steer memory ports
    always_comb
    begin
        ha_rd      = 1'b0;
        ha_raddr   = w;
        head_wr    = 1'b0;
        head_waddr = u_reg;
        head_wdata = slot0;
        link_wr    = 1'b0;
        link_waddr = slot0;
        link_wdata = '{next_valid: ha_vld_reg, next: ha_q, neighbor: v_reg};
        disc_wr    = 1'b0;
        case (cmd.op)
            OP_ADD:
            begin
                ha_rd    = 1'b1;
                ha_raddr = in_u;
            end
            OP_ADD_FIRST:
            begin
                head_wr = 1'b1;
                link_wr = 1'b1;
            end
            OP_ADD_SECOND:
            begin
                head_wr    = 1'b1;
                head_waddr = v_reg;
                head_wdata = slot1;
                link_wr    = 1'b1;
                link_waddr = slot1;
                link_wdata.neighbor = u_reg;
                if (u_reg == v_reg)
                begin
                    link_wdata.next_valid = 1'b1;
                    link_wdata.next       = slot0;
                end
                else
                begin
                    link_wdata.next_valid = hb_vld_reg;
                    link_wdata.next       = hb_q;
                end
            end
            OP_SCAN:
            begin
                ha_rd    = root_start;
                ha_raddr = idx_v;
                disc_wr  = root_start;
            end
            OP_EDGE_EVAL:
            begin
                ha_rd   = status.push;
                disc_wr = status.push;
            end
            default:
            begin
                ha_rd = 1'b0;
            end
        endcase
    end

    // Head memory: write one entry, read two
    always_ff @(posedge clk)
    begin
        if (head_wr)
        begin
            head_mem[head_waddr] <= head_wdata;
        end
        if (ha_rd)
        begin
            ha_q <= head_mem[ha_raddr];
        end
        if (cmd.op == OP_ADD)
        begin
            hb_q <= head_mem[in_v];
        end
    end

    // Link memory
    always_ff @(posedge clk)
    begin
        if (link_wr)
        begin
            link_mem[link_waddr] <= link_wdata;
        end
        if (cmd.op == OP_EDGE_READ)
        begin
            link_q <= link_mem[cur_reg.cursor];
        end
    end

    // Discovery time memory
    always_ff @(posedge clk)
    begin
        if (disc_wr)
        begin
            disc_mem[ha_raddr] <= vcnt_reg;
        end
        if ((cmd.op == OP_EDGE_EVAL) && status.back)
        begin
            disc_q <= disc_mem[w];
        end
    end

    // Search stack memory
    always_ff @(posedge clk)
    begin
        if ((cmd.op == OP_EDGE_EVAL) && status.push)
        begin
            stack_mem[stk_waddr] <= cur_adv;
        end
        if ((cmd.op == OP_POP) && cur_reg.has_parent)
        begin
            stk_q <= stack_mem[stk_raddr];
        end
    end

    // Advance the datapath state per command
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg   <= CFG_W'(1);
            stored_reg   <= '0;
            dropped_reg  <= 1'b0;
            err_reg      <= 1'b0;
            u_reg        <= '0;
            v_reg        <= '0;
            idx_reg      <= '0;
            top_reg      <= '0;
            vcnt_reg     <= DISC_W'(1);
            cur_reg      <= '0;
            popx_low_reg <= '0;
            visited_reg  <= '0;
            cut_reg      <= '0;
            head_vld_reg <= '0;
            ha_vld_reg   <= 1'b0;
            hb_vld_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                vcount_reg <= cfg_data;
            end
            if (ha_rd)
            begin
                ha_vld_reg <= head_vld_reg[ha_raddr];
            end
            case (cmd.op)
                OP_ADD:
                begin
                    hb_vld_reg <= head_vld_reg[in_v];
                    if (status.add_ok)
                    begin
                        u_reg <= in_u;
                        v_reg <= in_v;
                    end
                    else
                    begin
                        dropped_reg <= 1'b1;
                    end
                end
                OP_ADD_FIRST:
                begin
                    head_vld_reg[u_reg] <= 1'b1;
                end
                OP_ADD_SECOND:
                begin
                    head_vld_reg[v_reg] <= 1'b1;
                    stored_reg          <= stored_reg + EDGE_W'(1);
                end
                OP_START:
                begin
                    err_reg <= dropped_reg;
                    idx_reg <= '0;
                end
                OP_SCAN:
                begin
                    if (status.scan_end)
                    begin
                        idx_reg <= '0;
                    end
                    else if (status.scan_visited)
                    begin
                        idx_reg <= idx_reg + CNT_W'(1);
                    end
                    else
                    begin
                        visited_reg[idx_v] <= 1'b1;
                        cur_reg  <= '{node: idx_v, parent: '0, has_parent: 1'b0,
                                      cursor_valid: 1'b0, cursor: '0, kids: 2'b00,
                                      disc: vcnt_reg, low: vcnt_reg};
                        vcnt_reg <= vcnt_reg + DISC_W'(1);
                        top_reg  <= CNT_W'(1);
                    end
                end
                OP_LOAD_CURSOR:
                begin
                    cur_reg.cursor_valid <= ha_vld_reg;
                    cur_reg.cursor       <= ha_q;
                end
                OP_EDGE_EVAL:
                begin
                    if (status.push)
                    begin
                        visited_reg[w] <= 1'b1;
                        cur_reg  <= '{node: w, parent: cur_reg.node, has_parent: 1'b1,
                                      cursor_valid: 1'b0, cursor: '0, kids: 2'b00,
                                      disc: vcnt_reg, low: vcnt_reg};
                        vcnt_reg <= vcnt_reg + DISC_W'(1);
                        top_reg  <= top_reg + CNT_W'(1);
                    end
                    else
                    begin
                        cur_reg <= cur_adv;
                    end
                end
                OP_BACK_CMP:
                begin
                    if (disc_q < cur_reg.low)
                    begin
                        cur_reg.low <= disc_q;
                    end
                end
                OP_POP:
                begin
                    if (!cur_reg.has_parent)
                    begin
                        if (cur_reg.kids > 2'b01)
                        begin
                            cut_reg[cur_reg.node] <= 1'b1;
                        end
                        top_reg <= '0;
                        idx_reg <= idx_reg + CNT_W'(1);
                    end
                    else
                    begin
                        popx_low_reg <= cur_reg.low;
                        top_reg      <= top_reg - CNT_W'(1);
                    end
                end
                OP_POP_MERGE:
                begin
                    if ((popx_low_reg >= stk_q.disc) && stk_q.has_parent)
                    begin
                        cut_reg[stk_q.node] <= 1'b1;
                    end
                    cur_reg <= merged;
                end
                OP_EMIT:
                begin
                    if (any_cut)
                    begin
                        if (!cut_here)
                        begin
                            idx_reg <= idx_reg + CNT_W'(1);
                        end
                        else if (out_free)
                        begin
                            cut_reg[idx_v] <= 1'b0;
                        end
                    end
                end
                OP_CLEAR:
                begin
                    visited_reg  <= '0;
                    cut_reg      <= '0;
                    head_vld_reg <= '0;
                    stored_reg   <= '0;
                    vcnt_reg     <= DISC_W'(1);
                    dropped_reg  <= 1'b0;
                end
                default:
                begin
                    top_reg <= top_reg;
                end
            endcase
        end
    end

    // Hold the result beat until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            vertex_reg    <= '0;
            none_reg      <= 1'b0;
            err_out_reg   <= 1'b0;
            last_reg      <= 1'b0;
        end
        else if (emit_load)
        begin
            out_valid_reg <= 1'b1;
            vertex_reg    <= any_cut ? idx_v : '0;
            none_reg      <= !any_cut;
            err_out_reg   <= err_reg;
            last_reg      <= !any_cut || rest_empty;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign vertex     = VTX_OUT_W'(vertex_reg);
    assign none_found = none_reg;
    assign edge_error = err_out_reg;
    assign last       = last_reg;

    // Checks
    a_top_bound: assert property (@(posedge clk) disable iff (!rst_n)
        top_reg <= CNT_W'(MAX_VERTICES))
        else $error("search stack overflow");
    a_store_bound: assert property (@(posedge clk) disable iff (!rst_n)
        stored_reg <= EDGE_W'(MAX_EDGES))
        else $error("edge store count out of range");
    a_visit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        vcnt_reg <= DISC_W'(MAX_VERTICES + 1))
        else $error("visit counter out of range");
    a_none_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && none_reg |-> last_reg && (vertex_reg == '0))
        else $error("none-found beat not final");
    a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_CLEAR |=> (visited_reg == '0) && (stored_reg == '0))
        else $error("graph not cleared");

endmodule

>>> rtl/core/articulation_point_finder.sv
// Top level of the articulation point finder: controller plus datapath.
//
// Usage: write vertex_count on the cfg channel (cfg_ready is always high)
// while the block is idle. Send add-edge beats (req_type 0) on the input
// channel; a stored edge passes the add-first and add-second states, a
// dropped edge (endpoint out of range or store full) leaves the block idle
// and sets edge_error for the next compute. A compute beat (req_type 1) runs
// a depth-first search: the scan state walks the vertex indices, an adjacency
// entry passes edge-read and edge-evaluate (one link store read) and
// back-compare for a back edge, a tree vertex loads its cursor on entry and
// pops (and merges below the root) on return; then the emit state walks the
// vertex indices and sends the result beats, and a clear state ends it.
// in_ready is low for the whole compute. Result beats carry the cut vertices
// in ascending order with last on the final one, or one none_found beat.
// The result sits in an output register: a stalled receiver holds the
// emission walk, and edge beats are still taken while a result waits.
// Reset empties the graph and sets vertex_count to 1; no clearing pass is
// needed.
module articulation_point_finder
    import apf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 req_type,
    input  logic [V_W-1:0]       vertex_u,
    input  logic [V_W-1:0]       vertex_v,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [VTX_OUT_W-1:0] vertex,
    output logic                 none_found,
    output logic                 edge_error,
    output logic                 last
);

    ctl_cmd_t   cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    // Sequence the work
    apf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .req_type (req_type),
        .status   (status),
        .cmd      (cmd)
    );

    // Store and search the graph
    apf_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .in_u       (vertex_u),
        .in_v       (vertex_v),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .vertex     (vertex),
        .none_found (none_found),
        .edge_error (edge_error),
        .last       (last)
    );

endmodule

>>> tb/sv/articulation_point_finder_tb.sv
// Self-checking testbench for the articulation point finder: graph loads, cut-vertex search.
module articulation_point_finder_tb;
    import apf_pkg::*;

    localparam logic REQ_ADD     = 1'b0;
    localparam logic REQ_COMPUTE = 1'b1;

    typedef struct packed {
        logic [VTX_OUT_W-1:0] vertex;
        logic                 none_found;
        logic                 edge_error;
        logic                 last;
    } cut_result_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_W-1:0]     cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    logic                 req_type;
    logic [V_W-1:0]       vertex_u;
    logic [V_W-1:0]       vertex_v;
    logic                 out_valid;
    logic                 out_ready;
    logic [VTX_OUT_W-1:0] vertex;
    logic                 none_found;
    logic                 edge_error;
    logic                 last;

    // Predictor state: the graph as edge pairs
    int          model_count;
    int          edge_a[$];
    int          edge_b[$];
    bit          model_dropped;
    cut_result_t expected_cuts[$];

    int  mismatch_count;
    int  result_count;
    int  compute_count;
    int  edge_count;
    bit  hold_off;
    bit  idle_free;

    articulation_point_finder DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .req_type   (req_type),
        .vertex_u   (vertex_u),
        .vertex_v   (vertex_v),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .vertex     (vertex),
        .none_found (none_found),
        .edge_error (edge_error),
        .last       (last)
    );

    always #4 clk = ~clk;

    // Build adjacency lists newest first, same walk order as the block
    task automatic predict_cuts();
        int      n;
        int      adj[64][$];
        int      disc[64];
        int      lowv[64];
        bit      seen[64];
        bit      mark[64];
        int      st_node[64];
        int      st_par[64];
        bit      st_haspar[64];
        int      st_cur[64];
        int      st_kids[64];
        int      top;
        int      counter;
        int      x;
        int      w;
        int      y;
        int      found;
        cut_result_t r;
        n = model_count;
        for (int i = 0; i < 64; i++)
        begin
            adj[i] = {};
            seen[i] = 0;
            mark[i] = 0;
        end
        for (int k = 0; k < edge_a.size(); k++)
        begin
            adj[edge_a[k]].push_front(edge_b[k]);
            adj[edge_b[k]].push_front(edge_a[k]);
        end
        counter = 1;
        for (int root = 0; root < n; root++)
        begin
            if (seen[root])
                continue;
            top = 0;
            seen[root] = 1;
            disc[root] = counter;
            lowv[root] = counter;
            counter++;
            st_node[0] = root;
            st_par[0] = 0;
            st_haspar[0] = 0;
            st_cur[0] = 0;
            st_kids[0] = 0;
            top = 1;
            while (top > 0)
            begin
                x = st_node[top-1];
                if (st_cur[top-1] < adj[x].size())
                begin
                    w = adj[x][st_cur[top-1]];
                    st_cur[top-1]++;
                    if (st_haspar[top-1] && w == st_par[top-1])
                        continue;
                    if (!seen[w])
                    begin
                        seen[w] = 1;
                        disc[w] = counter;
                        lowv[w] = counter;
                        counter++;
                        st_node[top] = w;
                        st_par[top] = x;
                        st_haspar[top] = 1;
                        st_cur[top] = 0;
                        st_kids[top] = 0;
                        top++;
                    end
                    else if (disc[w] < lowv[x])
                        lowv[x] = disc[w];
                end
                else
                begin
                    top--;
                    if (!st_haspar[top])
                    begin
                        if (st_kids[top] > 1)
                            mark[x] = 1;
                    end
                    else if (top > 0)
                    begin
                        y = st_node[top-1];
                        if (lowv[x] < lowv[y])
                            lowv[y] = lowv[x];
                        if (lowv[x] >= disc[y] && st_haspar[top-1])
                            mark[y] = 1;
                        st_kids[top-1]++;
                    end
                end
            end
        end
        found = 0;
        for (int i = 0; i < n; i++)
        begin
            if (mark[i])
            begin
                r.vertex = VTX_OUT_W'(i);
                r.none_found = 0;
                r.edge_error = model_dropped;
                r.last = 0;
                expected_cuts = {expected_cuts, r};
                found++;
            end
        end
        if (found == 0)
        begin
            r.vertex = '0;
            r.none_found = 1;
            r.edge_error = model_dropped;
            r.last = 1;
            expected_cuts = {expected_cuts, r};
        end
        else
            expected_cuts[expected_cuts.size()-1].last = 1;
        edge_a = {};
        edge_b = {};
        model_dropped = 0;
    endtask

    // Drive one request beat and update the predictor on acceptance
    task automatic send_request(input logic kind, input int u, input int v);
        while (!idle_free && $urandom_range(99) < 37)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= kind;
        vertex_u <= u[V_W-1:0];
        vertex_v <= v[V_W-1:0];
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (kind == REQ_COMPUTE)
        begin
            predict_cuts();
            compute_count++;
        end
        else
        begin
            edge_count++;
            if (u >= model_count || v >= model_count || edge_a.size() >= MAX_EDGES)
                model_dropped = 1;
            else
            begin
                edge_a = {edge_a, u};
                edge_b = {edge_b, v};
            end
        end
    endtask

    // Wait for all results, then let the clear-down settle
    task automatic drain();
        in_valid <= 1'b0;
        while (expected_cuts.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_vertex_count(input int value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= value[CFG_W-1:0];
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        model_count = (value > MAX_VERTICES) ? MAX_VERTICES : value;
        @(posedge clk);
    endtask

    // Directed cases: path, star, triangle, self loop, drops, zero count
    task automatic test_directed();
        write_vertex_count(0);
        send_request(REQ_ADD, 0, 0);
        send_request(REQ_COMPUTE, 0, 0);
        write_vertex_count(5);
        send_request(REQ_ADD, 0, 1);
        send_request(REQ_ADD, 1, 2);
        send_request(REQ_ADD, 2, 3);
        send_request(REQ_ADD, 3, 3);
        send_request(REQ_COMPUTE, 63, 63);
        send_request(REQ_ADD, 0, 1);
        send_request(REQ_ADD, 1, 2);
        send_request(REQ_ADD, 2, 0);
        send_request(REQ_ADD, 63, 1);
        send_request(REQ_ADD, 1, 63);
        send_request(REQ_COMPUTE, 0, 0);
        write_vertex_count(127);
        send_request(REQ_ADD, 0, 63);
        send_request(REQ_ADD, 0, 62);
        send_request(REQ_ADD, 0, 21);
        send_request(REQ_ADD, 42, 42);
        send_request(REQ_COMPUTE, 0, 0);
        write_vertex_count(1);
        send_request(REQ_ADD, 0, 0);
        send_request(REQ_COMPUTE, 0, 0);
    endtask

    // Fill the edge store past capacity so the overflow drop is seen
    task automatic test_store_full();
        write_vertex_count(64);
        for (int k = 0; k < MAX_EDGES + 2; k++)
            send_request(REQ_ADD, $urandom_range(63), $urandom_range(63));
        send_request(REQ_COMPUTE, 0, 0);
    endtask

    // Random graphs of varied size and density, some with bad endpoints
    task automatic test_random_graphs(input int budget);
        int n;
        int edges;
        int sent;
        sent = 0;
        while (sent < budget)
        begin
            case ($urandom_range(3))
                0: n = $urandom_range(2, 8);
                1: n = $urandom_range(9, 24);
                2: n = 64;
                default: n = $urandom_range(25, 70);
            endcase
            write_vertex_count(n);
            if (n > MAX_VERTICES)
                n = MAX_VERTICES;
            edges = $urandom_range(1, 2 * n);
            if (edges > budget - sent - 1)
                edges = budget - sent - 1;
            for (int k = 0; k < edges; k++)
            begin
                if ($urandom_range(19) == 0)
                    send_request(REQ_ADD, $urandom_range(63), $urandom_range(63));
                else
                    send_request(REQ_ADD, $urandom_range(n - 1), $urandom_range(n - 1));
                sent++;
            end
            send_request(REQ_COMPUTE, $urandom_range(63), $urandom_range(63));
            sent++;
        end
    endtask

    // Stall the receiver long while edges and computes keep coming
    task automatic test_backpressure();
        write_vertex_count(16);
        hold_off = 1;
        for (int r = 0; r < 3; r++)
        begin
            for (int k = 0; k < 12; k++)
                send_request(REQ_ADD, $urandom_range(15), $urandom_range(15));
            send_request(REQ_COMPUTE, 0, 0);
        end
    endtask

    // Release the receiver after a long counted stall
    always @(posedge clk)
    begin
        if (hold_off)
        begin
            repeat (300) @(posedge clk);
            hold_off <= 1'b0;
        end
    end

    // Receiver ready with random idling
    always @(posedge clk)
    begin
        if (hold_off)
            out_ready <= 1'b0;
        else
            out_ready <= idle_free || ($urandom_range(99) >= 37);
    end

    // Compare each result beat with the oldest expectation
    always @(posedge clk)
    begin
        cut_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            result_count++;
            if (expected_cuts.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected result vertex=%0d none=%0b err=%0b last=%0b",
                         $time, vertex, none_found, edge_error, last);
            end
            else
            begin
                want = expected_cuts.pop_front();
                if (vertex !== want.vertex)
                begin
                    mismatch_count++;
                    $display("%0t: vertex expected %0d actual %0d", $time, want.vertex, vertex);
                end
                if (none_found !== want.none_found)
                begin
                    mismatch_count++;
                    $display("%0t: none_found expected %0b actual %0b",
                             $time, want.none_found, none_found);
                end
                if (edge_error !== want.edge_error)
                begin
                    mismatch_count++;
                    $display("%0t: edge_error expected %0b actual %0b",
                             $time, want.edge_error, edge_error);
                end
                if (last !== want.last)
                begin
                    mismatch_count++;
                    $display("%0t: last expected %0b actual %0b", $time, want.last, last);
                end
            end
        end
    end

    initial
    begin
        clk = 0;
        rst_n = 0;
        cfg_valid = 0;
        cfg_data = '0;
        in_valid = 0;
        req_type = 0;
        vertex_u = '0;
        vertex_v = '0;
        out_ready = 0;
        hold_off = 0;
        idle_free = 0;
        mismatch_count = 0;
        result_count = 0;
        compute_count = 0;
        edge_count = 0;
        model_count = 1;
        model_dropped = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_store_full();
        test_backpressure();
        idle_free = 1;
        test_random_graphs(20);
        idle_free = 0;
        test_random_graphs(20);
        drain();
        if (expected_cuts.size() != 0)
            mismatch_count++;
        $display("Covered %0d edge beats and %0d searches, %0d result beats checked.",
                 edge_count, compute_count, result_count);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Hard stop on a hung run
    initial
    begin
        #200000000;
        $display("Mismatches found");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/apf_pkg.sv
rtl/core/apf_ctrl.sv
rtl/core/apf_datapath.sv
rtl/core/articulation_point_finder.sv
tb/sv/articulation_point_finder_tb.sv
